// File: rtl/sbda_pkg.sv
// shared types and constants for the signed binary to decimal ascii converter
// no dependencies; used by sbda_front, sbda_fifo, sbda_back and the top level

package sbda_pkg;

    localparam int IN_WIDTH = 64;

    localparam logic [5:0] MINUS_CODE = 6'd45;
    localparam logic [5:0] ZERO_CODE  = 6'd48;
    localparam logic [5:0] NINE_CODE  = 6'd57;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LEN,
        ST_EMIT
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: rtl/signed_binary_to_decimal_ascii.sv
// Signed binary to decimal ASCII converter, top level.
// Depends on sbda_pkg, sbda_front, sbda_fifo and sbda_back.
//
// Input channel: a signed value is written with push while full is low; only
// the low VALUE_WIDTH bits of i_value are used, the top one being the sign.
// Output channel: one ASCII character per transaction, most significant
// first, a leading '-' for negative values, no leading zeros, '0' for zero;
// o_last_char marks the final character. A character waits on the ports
// while empty is low and is taken with pop.
// A value passes the front register and the two-entry queue; the back stage
// then runs STEPS conversion steps, STEPS = ceil(VALUE_WIDTH / 4), 16 at 64
// bits, and a length step, and emits the characters into the output register
// one a cycle while the receiver pops. It converts four bits a cycle and
// takes no new value until its last character is out; the front stage and
// the two-entry queue take the following values meanwhile.
// Reset clears the queue, the back-stage state and all valid flags; nothing else is held.
// A stalled receiver holds the current character and the back stage; the
// queue and front stage fill up and then full rises.

module signed_binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [sbda_pkg::IN_WIDTH-1:0] i_value,
    output logic                                empty,
    input  logic                                pop,
    output logic [5:0]                          o_char_code,
    output logic                                o_last_char
);

    logic                   w_front_valid;
    logic                   w_front_neg;
    logic [VALUE_WIDTH-1:0] w_front_mag;
    logic                   w_front_take;
    sbda_pkg::t_q_status    w_q_status;
    logic [VALUE_WIDTH:0]   w_q_data;
    logic                   w_back_take;

    assign w_front_take = w_front_valid && !w_q_status.full;

    sbda_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_value      (i_value),
        .o_item_valid (w_front_valid),
        .o_item_neg   (w_front_neg),
        .o_item_mag   (w_front_mag),
        .i_item_take  (w_front_take)
    );

    sbda_fifo #(
        .DATA_W(VALUE_WIDTH + 1)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_front_take),
        .i_data   ({w_front_neg, w_front_mag}),
        .i_rd     (w_back_take),
        .o_data   (w_q_data),
        .o_status (w_q_status)
    );

    sbda_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!w_q_status.empty),
        .i_item_neg   (w_q_data[VALUE_WIDTH]),
        .i_item_mag   (w_q_data[VALUE_WIDTH-1:0]),
        .o_item_take  (w_back_take),
        .empty        (empty),
        .pop          (pop),
        .o_char_code  (o_char_code),
        .o_last_char  (o_last_char)
    );

endmodule

// File: rtl/sbda_front.sv
// front stage: accepts a value, splits it into sign and magnitude
// depends on sbda_pkg for the input port width

module sbda_front #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [sbda_pkg::IN_WIDTH-1:0] i_value,
    output logic                                o_item_valid,
    output logic                                o_item_neg,
    output logic [VALUE_WIDTH-1:0]              o_item_mag,
    input  logic                                i_item_take
);

    logic                   r_valid;
    logic                   n_valid;
    logic                   r_neg;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [VALUE_WIDTH-1:0] w_bits;
    logic                   w_accept;

    assign w_bits   = i_value[VALUE_WIDTH-1:0];
    assign full     = r_valid && !i_item_take;
    assign w_accept = push && !full;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_item_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // the most negative value negates to 2^(w-1), which still fits unsigned
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg <= w_bits[VALUE_WIDTH-1];
            r_mag <= w_bits[VALUE_WIDTH-1] ? (~w_bits + 1'b1) : w_bits;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item_neg   = r_neg;
    assign o_item_mag   = r_mag;

endmodule

// File: rtl/sbda_fifo.sv
// two-entry queue between the front stage and the back stage
// depends on sbda_pkg for the status struct

module sbda_fifo #(
    parameter int DATA_W = 65
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  logic [DATA_W-1:0]   i_data,
    input  logic                i_rd,
    output logic [DATA_W-1:0]   o_data,
    output sbda_pkg::t_q_status o_status
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign w_wr           = i_wr && !o_status.full;
    assign w_rd           = i_rd && !o_status.empty;
    assign o_data         = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wptr <= ~r_wptr;
            end
            if (w_rd) begin
                r_rptr <= ~r_rptr;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");

    a_full_write_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && o_status.full && !i_rd) |=> $stable(r_count))
        else $error("write into full queue changed count");

endmodule

// File: rtl/sbda_back.sv
// back stage: magnitude to bcd by shift-add-3, four bits a cycle, then one character
// a cycle into the output register while the receiver pops; depends on sbda_pkg

module sbda_back #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_item_valid,
    input  logic                   i_item_neg,
    input  logic [VALUE_WIDTH-1:0] i_item_mag,
    output logic                   o_item_take,
    output logic                   empty,
    input  logic                   pop,
    output logic [5:0]             o_char_code,
    output logic                   o_last_char
);

    localparam int STEPS = (VALUE_WIDTH + 3) / 4;
    localparam int PADW  = STEPS * 4;
    localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCDW  = NDIG * 4;
    localparam int IDXW  = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int CNTW  = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNTW-1:0] LAST_STEP = CNTW'(STEPS - 1);

    sbda_pkg::t_back_state r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [PADW-1:0] r_mag, n_mag;
    logic [BCDW-1:0] r_bcd, n_bcd;
    logic            r_neg, n_neg;
    logic [IDXW-1:0] r_idx, n_idx;
    logic            r_oval, n_oval;
    logic [5:0]      r_char, n_char;
    logic            r_last, n_last;

    logic [BCDW-1:0] w_bcd;
    logic [PADW-1:0] w_mag;
    logic [IDXW-1:0] w_top;
    logic [3:0]      w_digit;
    logic            w_slot;

    // four shift-add-3 steps, each over all digits in parallel
    always_comb begin : p_dabble
        logic [BCDW-1:0] v_bcd;
        logic [PADW-1:0] v_mag;
        v_bcd = r_bcd;
        v_mag = r_mag;
        for (int s = 0; s < 4; s++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (v_bcd[d*4 +: 4] >= 4'd5) begin
                    v_bcd[d*4 +: 4] = v_bcd[d*4 +: 4] + 4'd3;
                end
            end
            {v_bcd, v_mag} = {v_bcd, v_mag} << 1;
        end
        w_bcd = v_bcd;
        w_mag = v_mag;
    end

    // highest nonzero digit; zero keeps a single digit
    always_comb begin
        w_top = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*4 +: 4] != 4'd0) begin
                w_top = IDXW'(d);
            end
        end
    end

    assign w_digit = r_bcd[{r_idx, 2'b00} +: 4];
    assign w_slot  = !r_oval || pop;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_mag       = r_mag;
        n_bcd       = r_bcd;
        n_neg       = r_neg;
        n_idx       = r_idx;
        n_oval      = r_oval && !pop;
        n_char      = r_char;
        n_last      = r_last;
        o_item_take = 1'b0;
        case (r_state)
            sbda_pkg::ST_IDLE: begin
                if (i_item_valid) begin
                    o_item_take = 1'b1;
                    n_mag       = PADW'(i_item_mag);
                    n_neg       = i_item_neg;
                    n_bcd       = '0;
                    n_cnt       = '0;
                    n_state     = sbda_pkg::ST_CONV;
                end
            end
            sbda_pkg::ST_CONV: begin
                n_bcd = w_bcd;
                n_mag = w_mag;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = sbda_pkg::ST_LEN;
                end
            end
            sbda_pkg::ST_LEN: begin
                n_idx   = w_top;
                n_state = sbda_pkg::ST_EMIT;
            end
            sbda_pkg::ST_EMIT: begin
                if (w_slot) begin
                    n_oval = 1'b1;
                    if (r_neg) begin
                        n_char = sbda_pkg::MINUS_CODE;
                        n_last = 1'b0;
                        n_neg  = 1'b0;
                    end else begin
                        n_char = sbda_pkg::ZERO_CODE + {2'b00, w_digit};
                        n_last = (r_idx == '0);
                        if (r_idx == '0) begin
                            n_state = sbda_pkg::ST_IDLE;
                        end else begin
                            n_idx = r_idx - 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = sbda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbda_pkg::ST_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_neg  <= n_neg;
        r_idx  <= n_idx;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign empty       = !r_oval;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_char_code != sbda_pkg::MINUS_CODE) |->
        (o_char_code >= sbda_pkg::ZERO_CODE && o_char_code <= sbda_pkg::NINE_CODE))
        else $error("character outside digit range");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_char_code == sbda_pkg::MINUS_CODE) |-> !o_last_char)
        else $error("minus sign flagged as last character");

    a_conv_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbda_pkg::ST_CONV && r_cnt != LAST_STEP) |=>
        (r_state == sbda_pkg::ST_CONV))
        else $error("conversion left before its last step");

endmodule

// File: dv/signed_binary_to_decimal_ascii_tb.sv
// testbench for signed_binary_to_decimal_ascii: checks the decimal text of signed values
// depends on sbda_pkg and the top level; predicts each character run and checks it in order

`timescale 1ns / 100ps

module signed_binary_to_decimal_ascii_tb;

    localparam int VALUE_WIDTH = 64;
    localparam int MAX_CHARS   = 20;
    localparam int RESET_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 134;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct {
        logic [5:0] code;
        logic       last;
    } t_char_result;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 push = 1'b0;
    logic                                 pop = 1'b0;
    logic signed [sbda_pkg::IN_WIDTH-1:0] i_value = '0;
    logic                                 full;
    logic                                 empty;
    logic [5:0]                           o_char_code;
    logic                                 o_last_char;

    t_char_result expected_chars[$];
    t_char_result oldest_char;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           hold_request = 1'b0;

    signed_binary_to_decimal_ascii #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_value    (i_value),
        .empty      (empty),
        .pop        (pop),
        .o_char_code(o_char_code),
        .o_last_char(o_last_char)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // appends the expected decimal text of one value to the expected queue
    function automatic void predict_decimal_text(input logic [63:0] value);
        logic [63:0]  mask;
        logic [63:0]  bits;
        logic [63:0]  mag;
        logic         negative;
        logic [3:0]   digits[MAX_CHARS];
        int           ndig;
        int           total;
        int           k;
        t_char_result ch;
        mask = {64{1'b1}} >> (64 - VALUE_WIDTH);
        bits = value & mask;
        negative = bits[VALUE_WIDTH-1];
        mag = negative ? ((64'd0 - bits) & mask) : bits;
        ndig = 0;
        do begin
            digits[ndig] = 4'(mag % 64'd10);
            ndig++;
            mag = mag / 64'd10;
        end while (mag != 0 && ndig < MAX_CHARS - 1);
        total = ndig + (negative ? 1 : 0);
        k = 0;
        if (negative) begin
            ch.code = sbda_pkg::MINUS_CODE;
            ch.last = (k == total - 1);
            expected_chars.push_back(ch);
            k++;
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            ch.code = sbda_pkg::ZERO_CODE + 6'(digits[i]);
            ch.last = (k == total - 1);
            expected_chars.push_back(ch);
            k++;
        end
    endfunction

    // holds push high until the transaction is taken; leaves push high for a following one
    task automatic send_value(input logic [63:0] value);
        push <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (full);
        predict_decimal_text(value);
    endtask

    task automatic idle_sender(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        push <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] power_of_ten(input int exp10);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < exp10; i++) p = p * 64'd10;
        return p;
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: ;
            1: v = 64'($urandom_range(0, 999));
            // random digit count
            2: v = v >> $urandom_range(1, 63);
            3: v = power_of_ten($urandom_range(0, 18)) + 64'($urandom_range(0, 2)) - 64'd1;
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 64'd1 << (VALUE_WIDTH - 1);
                    1: v = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
                    2: v = 64'd0;
                    default: v = {64{1'b1}};
                endcase
            end
        endcase
        if ($urandom_range(0, 1) == 1) v = 64'd0 - v;
        return v;
    endfunction

    // receiver: stall patterns in random stretches, plus a long hold-off on request
    initial begin
        int mode;
        int len;
        int n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                len = $urandom_range(5, 40);
                n = 0;
                while (n < len && !hold_request) begin
                    case (mode)
                        0: pop <= 1'b1;
                        1: pop <= ($urandom_range(0, 1) == 1);
                        2: pop <= (n % 4 == 0);
                        default: pop <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge i_clk);
                    n++;
                end
            end
        end
    end

    // compares every accepted character with the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected transaction, char_code %0d last_char %0b",
                         $time, o_char_code, o_last_char);
                mismatch_count++;
            end else begin
                oldest_char = expected_chars.pop_front();
                if (o_char_code !== oldest_char.code) begin
                    $display("%0t: char_code mismatch, expected %0d actual %0d",
                             $time, oldest_char.code, o_char_code);
                    mismatch_count++;
                end
                if (o_last_char !== oldest_char.last) begin
                    $display("%0t: last_char mismatch, expected %0b actual %0b",
                             $time, oldest_char.last, o_last_char);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [63:0] most_negative;
        most_negative = 64'd1 << (VALUE_WIDTH - 1);
        send_value(64'd0);
        send_value(64'd1);
        send_value({64{1'b1}});
        send_value(64'd9);
        send_value(64'd10);
        send_value(64'd0 - 64'd10);
        send_value(64'd99);
        send_value(64'd100);
        send_value(most_negative);
        send_value(most_negative - 64'd1);
        send_value(most_negative + 64'd1);
        send_value(power_of_ten(18) - 64'd1);
        send_value(power_of_ten(18));
        send_value(64'd0 - power_of_ten(18));
        send_value(64'd1234567890123456789);
        send_value(64'h5555_5555_5555_5555);
        send_value(64'hAAAA_AAAA_AAAA_AAAA);
        send_value(64'd0 - 64'd5);
        idle_sender(3);
    endtask

    task automatic test_random_values(input int count);
        int burst;
        int sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_value(random_value());
                sent++;
            end
            case ($urandom_range(0, 5))
                0: ;
                1: wait_for_drain();
                default: idle_sender($urandom_range(1, 30));
            endcase
        end
    endtask

    // receiver stops for a long stretch while values keep coming, so full must rise
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 10; i++) send_value(random_value());
        push <= 1'b0;
        wait (!hold_request);
        @(posedge i_clk);
    endtask

    task automatic test_pause_until_drained();
        for (int i = 0; i < 4; i++) send_value(random_value());
        wait_for_drain();
        for (int i = 0; i < 4; i++) send_value(random_value());
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random_values(RANDOM_ITEMS);
        test_pause_until_drained();
        wait_for_drain();
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("PASS signed_binary_to_decimal_ascii");
        end else begin
            $display("FAIL signed_binary_to_decimal_ascii");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout, %0d characters still expected", $time, expected_chars.size());
        $display("FAIL signed_binary_to_decimal_ascii");
        $finish;
    end

endmodule
